// ===== rtl/otss_pkg.sv =====
// Package for the one-shot timer slot scheduler: codes, types and default sizes.
`timescale 1ns / 1ps
`default_nettype none
package otss_pkg;

   localparam int DEF_SLOTS     = 32;
   localparam int DEF_TIME_BITS = 48;
   localparam int DEF_ID_BITS   = 16;
   localparam int DEF_TAG_BITS  = 16;
   localparam int DELAY_BITS    = 31;
   localparam int OP_BITS       = 2;
   localparam int KIND_BITS     = 3;

   typedef enum logic [OP_BITS-1:0] {
      OP_TICK     = 2'd0,
      OP_SCHEDULE = 2'd1,
      OP_CANCEL   = 2'd2
   } op_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_FIRED     = 3'd0,
      KIND_SCHEDULED = 3'd1,
      KIND_FULL      = 3'd2,
      KIND_CANCELLED = 3'd3,
      KIND_NOT_FOUND = 3'd4,
      KIND_TICK_DONE = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_TICK_DONE,
      ST_SCHED,
      ST_CANCEL
   } state_type;

   // Flags from the shared add/subtract unit.
   typedef struct packed {
      logic carry;
      logic zero;
   } alu_flags_type;

endpackage
`default_nettype wire

// ===== rtl/otss_alu.sv =====
// Shared adder/subtractor used for deadline sums, expiry compares and id matches.
`timescale 1ns / 1ps
`default_nettype none
module otss_alu #(
   parameter int WIDTH = otss_pkg::DEF_TIME_BITS
) (
   input  wire logic [WIDTH-1:0]        a,
   input  wire logic [WIDTH-1:0]        b,
   input  wire logic                    sub,
   output logic      [WIDTH-1:0]        sum,
   output otss_pkg::alu_flags_type      flags
);
   import otss_pkg::*;

   logic [WIDTH-1:0] b_eff;
   logic [WIDTH:0]   total;

   // With sub set, carry out high means a >= b, and a zero result means a == b.
   assign b_eff = sub ? ~b : b;
   assign total = {1'b0, a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, sub};
   assign sum   = total[WIDTH-1:0];
   assign flags.carry = total[WIDTH];
   assign flags.zero  = (total[WIDTH-1:0] == '0);

endmodule
`default_nettype wire

// ===== rtl/otss_slot_mem.sv =====
// Slot memory holding deadline, tag and id per slot, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module otss_slot_mem #(
   parameter int DEPTH      = otss_pkg::DEF_SLOTS,
   parameter int WORD_BITS  = otss_pkg::DEF_TIME_BITS + otss_pkg::DEF_TAG_BITS
                              + otss_pkg::DEF_ID_BITS,
   parameter int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WORD_BITS-1:0] wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WORD_BITS-1:0] rd_data
);
   import otss_pkg::*;

   logic [WORD_BITS-1:0] mem_ff [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/otss_ctrl.sv =====
// Sequencer: slot scan, valid bits, id counter and result registers.
`timescale 1ns / 1ps
`default_nettype none
module otss_ctrl #(
   parameter int SLOTS     = otss_pkg::DEF_SLOTS,
   parameter int TIME_BITS = otss_pkg::DEF_TIME_BITS,
   parameter int ID_BITS   = otss_pkg::DEF_ID_BITS,
   parameter int TAG_BITS  = otss_pkg::DEF_TAG_BITS,
   parameter int IDX_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   parameter int WORD_BITS = TIME_BITS + TAG_BITS + ID_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            accept,
   input  wire logic [otss_pkg::OP_BITS-1:0]    op,
   input  wire logic [TIME_BITS-1:0]            now_ms,
   input  wire logic [otss_pkg::DELAY_BITS-1:0] delay_ms,
   input  wire logic [TAG_BITS-1:0]             event_tag,
   input  wire logic [ID_BITS-1:0]              cancel_id,
   output logic                                 busy,
   output logic                                 mem_we,
   output logic      [IDX_BITS-1:0]             mem_waddr,
   output logic      [WORD_BITS-1:0]            mem_wdata,
   output logic      [IDX_BITS-1:0]             mem_raddr,
   input  wire logic [WORD_BITS-1:0]            mem_rdata,
   output logic      [TIME_BITS-1:0]            alu_a,
   output logic      [TIME_BITS-1:0]            alu_b,
   output logic                                 alu_sub,
   input  wire logic [TIME_BITS-1:0]            alu_sum,
   input  wire otss_pkg::alu_flags_type         alu_flags,
   output logic                                 rsp_valid,
   output logic      [otss_pkg::KIND_BITS-1:0]  rsp_kind,
   output logic      [ID_BITS-1:0]              rsp_timer_id,
   output logic      [TAG_BITS-1:0]             rsp_fired_tag,
   output logic                                 rsp_last
);
   import otss_pkg::*;

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SLOTS - 1);

   state_type           state_ff, state_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic [SLOTS-1:0]    active_ff, active_in;
   logic [SLOTS-1:0]    id_valid_ff, id_valid_in;
   logic [ID_BITS-1:0]  next_id_ff, next_id_in;
   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            rsp_kind_ff, rsp_kind_in;
   logic [ID_BITS-1:0]  rsp_id_ff, rsp_id_in;
   logic [TAG_BITS-1:0] rsp_tag_ff, rsp_tag_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [TIME_BITS-1:0] rd_deadline;
   logic [TAG_BITS-1:0]  rd_tag;
   logic [ID_BITS-1:0]   rd_id;
   logic [TIME_BITS-1:0] sat_sum;

   // Memory word layout: deadline, then tag, then id.
   assign rd_deadline = mem_rdata[WORD_BITS-1 -: TIME_BITS];
   assign rd_tag      = mem_rdata[ID_BITS +: TAG_BITS];
   assign rd_id       = mem_rdata[ID_BITS-1:0];
   assign sat_sum     = alu_flags.carry ? {TIME_BITS{1'b1}} : alu_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         id_valid_ff  <= '0;
         next_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         id_valid_ff  <= id_valid_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Operand selection for the shared unit.
   always_comb begin
      unique case (state_ff)
         ST_TICK: begin
            alu_a   = now_ms;
            alu_b   = rd_deadline;
            alu_sub = 1'b1;
         end
         ST_SCHED: begin
            alu_a   = now_ms;
            alu_b   = TIME_BITS'(delay_ms);
            alu_sub = 1'b0;
         end
         ST_CANCEL: begin
            alu_a   = TIME_BITS'(cancel_id);
            alu_b   = TIME_BITS'(rd_id);
            alu_sub = 1'b1;
         end
         default: begin
            alu_a   = '0;
            alu_b   = '0;
            alu_sub = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      active_in    = active_ff;
      id_valid_in  = id_valid_ff;
      next_id_in   = next_id_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = KIND_TICK_DONE;
      rsp_id_in    = '0;
      rsp_tag_in   = '0;
      rsp_last_in  = 1'b0;
      mem_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
               unique case (op)
                  OP_TICK:     state_in = ST_TICK;
                  OP_SCHEDULE: state_in = ST_SCHED;
                  OP_CANCEL:   state_in = ST_CANCEL;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_TICK: begin
            // Carry out of now - deadline means the deadline has passed.
            if (active_ff[idx_ff] && alu_flags.carry) begin
               active_in[idx_ff] = 1'b0;
               if (rd_tag != '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_FIRED;
                  rsp_tag_in   = rd_tag;
               end
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_TICK_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_TICK_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_TICK_DONE;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCHED: begin
            if (!active_ff[idx_ff]) begin
               mem_we               = 1'b1;
               active_in[idx_ff]    = 1'b1;
               id_valid_in[idx_ff]  = 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_kind_in          = KIND_SCHEDULED;
               rsp_id_in            = next_id_ff;
               rsp_last_in          = 1'b1;
               next_id_in           = next_id_ff + 1'b1;
               state_in             = ST_IDLE;
            end else if (idx_ff == LAST_IDX) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FULL;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_CANCEL: begin
            if (id_valid_ff[idx_ff] && alu_flags.zero) begin
               active_in[idx_ff]   = 1'b0;
               id_valid_in[idx_ff] = 1'b0;
               rsp_valid_in        = 1'b1;
               rsp_kind_in         = KIND_CANCELLED;
               rsp_last_in         = 1'b1;
               state_in            = ST_IDLE;
            end else if (idx_ff == LAST_IDX) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_NOT_FOUND;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The read address runs one step ahead so the registered data matches idx_ff.
   assign mem_raddr = idx_in;
   assign mem_waddr = idx_ff;
   assign mem_wdata = {sat_sum, event_tag, next_id_ff};
   assign busy      = (state_ff != ST_IDLE);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_timer_id  = rsp_id_ff;
   assign rsp_fired_tag = rsp_tag_ff;
   assign rsp_last      = rsp_last_ff;

   // A pending timer always owns a live id.
   a_active_has_id: assert property (@(posedge clock) disable iff (reset)
      (active_ff & ~id_valid_ff) == '0)
      else $error("active slot without a live id");

   a_tick_done_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TICK_DONE |=> rsp_valid_ff && rsp_last_ff
                                   && rsp_kind_ff == KIND_TICK_DONE)
      else $error("tick scan did not end with a tick-done result");

   a_fired_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_FIRED |->
         !rsp_last_ff && rsp_id_ff == '0 && rsp_tag_ff != '0)
      else $error("fired result with bad fields");

   a_write_free_slot: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == ST_SCHED && !active_ff[idx_ff])
      else $error("slot memory written outside a schedule of a free slot");

endmodule
`default_nettype wire

// ===== rtl/one_shot_timer_slot_scheduler.sv =====
// Top level of the one-shot timer slot scheduler: request capture and unit wiring.
//
//   channel   ports                                      handshake
//   request   req_op req_now_ms req_delay_ms             start high, busy low
//             req_event_tag req_cancel_id
//   result    rsp_kind rsp_timer_id rsp_fired_tag        rsp_valid, one cycle each
//             rsp_last
//
// One item is worked at a time while busy is high. The scan visits one slot per cycle
// through the slot memory read port and the shared adder. A tick visits every slot, a
// schedule or cancel stops at a free or matching slot, op 3 gives no result. Each result
// is registered, valid in the cycle after the scan step that makes it; the receiver cannot
// stall. Reset clears the state, the active and id-valid bits and the id counter at once.
`timescale 1ns / 1ps
`default_nettype none
module one_shot_timer_slot_scheduler #(
   parameter int SLOTS     = otss_pkg::DEF_SLOTS,
   parameter int TIME_BITS = otss_pkg::DEF_TIME_BITS,
   parameter int ID_BITS   = otss_pkg::DEF_ID_BITS,
   parameter int TAG_BITS  = otss_pkg::DEF_TAG_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [otss_pkg::OP_BITS-1:0]    req_op,
   input  wire logic [TIME_BITS-1:0]            req_now_ms,
   input  wire logic [otss_pkg::DELAY_BITS-1:0] req_delay_ms,
   input  wire logic [TAG_BITS-1:0]             req_event_tag,
   input  wire logic [ID_BITS-1:0]              req_cancel_id,
   output logic                                 rsp_valid,
   output logic      [otss_pkg::KIND_BITS-1:0]  rsp_kind,
   output logic      [ID_BITS-1:0]              rsp_timer_id,
   output logic      [TAG_BITS-1:0]             rsp_fired_tag,
   output logic                                 rsp_last
);
   import otss_pkg::*;

   localparam int IDX_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int WORD_BITS = TIME_BITS + TAG_BITS + ID_BITS;

   logic                  accept;
   logic [TIME_BITS-1:0]  now_ff;
   logic [DELAY_BITS-1:0] delay_ff;
   logic [TAG_BITS-1:0]   tag_ff;
   logic [ID_BITS-1:0]    cid_ff;

   logic                 mem_we;
   logic [IDX_BITS-1:0]  mem_waddr, mem_raddr;
   logic [WORD_BITS-1:0] mem_wdata, mem_rdata;
   logic [TIME_BITS-1:0] alu_a, alu_b, alu_sum;
   logic                 alu_sub;
   alu_flags_type        alu_flags;

   assign accept = start && !busy;

   // The request fields are held for the whole scan.
   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff   <= req_now_ms;
         delay_ff <= req_delay_ms;
         tag_ff   <= req_event_tag;
         cid_ff   <= req_cancel_id;
      end
   end

   otss_slot_mem #(
      .DEPTH     (SLOTS),
      .WORD_BITS (WORD_BITS),
      .ADDR_BITS (IDX_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   otss_alu #(
      .WIDTH (TIME_BITS)
   ) u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .sub   (alu_sub),
      .sum   (alu_sum),
      .flags (alu_flags)
   );

   otss_ctrl #(
      .SLOTS     (SLOTS),
      .TIME_BITS (TIME_BITS),
      .ID_BITS   (ID_BITS),
      .TAG_BITS  (TAG_BITS),
      .IDX_BITS  (IDX_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .op            (req_op),
      .now_ms        (now_ff),
      .delay_ms      (delay_ff),
      .event_tag     (tag_ff),
      .cancel_id     (cid_ff),
      .busy          (busy),
      .mem_we        (mem_we),
      .mem_waddr     (mem_waddr),
      .mem_wdata     (mem_wdata),
      .mem_raddr     (mem_raddr),
      .mem_rdata     (mem_rdata),
      .alu_a         (alu_a),
      .alu_b         (alu_b),
      .alu_sub       (alu_sub),
      .alu_sum       (alu_sum),
      .alu_flags     (alu_flags),
      .rsp_valid     (rsp_valid),
      .rsp_kind      (rsp_kind),
      .rsp_timer_id  (rsp_timer_id),
      .rsp_fired_tag (rsp_fired_tag),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire

// ===== test/otss_checker.sv =====
// Checker for the one-shot timer slot scheduler: predicts each result and compares it.
`timescale 1ns / 1ps
module otss_checker #(
   parameter int SLOTS     = otss_pkg::DEF_SLOTS,
   parameter int TIME_BITS = otss_pkg::DEF_TIME_BITS,
   parameter int ID_BITS   = otss_pkg::DEF_ID_BITS,
   parameter int TAG_BITS  = otss_pkg::DEF_TAG_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  wire logic [otss_pkg::OP_BITS-1:0]    req_op,
   input  wire logic [TIME_BITS-1:0]            req_now_ms,
   input  wire logic [otss_pkg::DELAY_BITS-1:0] req_delay_ms,
   input  wire logic [TAG_BITS-1:0]             req_event_tag,
   input  wire logic [ID_BITS-1:0]              req_cancel_id,
   input  wire logic                            rsp_valid,
   input  wire logic [otss_pkg::KIND_BITS-1:0]  rsp_kind,
   input  wire logic [ID_BITS-1:0]              rsp_timer_id,
   input  wire logic [TAG_BITS-1:0]             rsp_fired_tag,
   input  wire logic                            rsp_last,
   output int                                   fail_count,
   output int                                   pending
);
   import otss_pkg::*;

   typedef struct {
      kind_type              kind;
      logic [ID_BITS-1:0]    timer_id;
      logic [TAG_BITS-1:0]   fired_tag;
      logic                  last;
   } timer_result_type;

   logic [TIME_BITS-1:0] due_ms [SLOTS];
   logic [TAG_BITS-1:0]  tag_of [SLOTS];
   logic [ID_BITS-1:0]   id_of  [SLOTS];
   bit                   armed  [SLOTS];
   bit                   id_live[SLOTS];
   logic [ID_BITS-1:0]   id_counter;

   timer_result_type pending_results[$];
   int               mismatches = 0;

   task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
   endtask

   function automatic void queue_result(kind_type k, logic [ID_BITS-1:0] id,
                                        logic [TAG_BITS-1:0] tag, logic last);
      timer_result_type r;
      r.kind      = k;
      r.timer_id  = id;
      r.fired_tag = tag;
      r.last      = last;
      pending_results.push_back(r);
   endfunction

   task automatic apply_timer_op();
      int                 slot;
      logic [TIME_BITS:0] sum;
      slot = 0;
      case (req_op)
         OP_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (armed[i] && due_ms[i] <= req_now_ms) begin
                  armed[i] = 1'b0;
                  if (tag_of[i] != '0)
                     queue_result(KIND_FIRED, '0, tag_of[i], 1'b0);
               end
            end
            queue_result(KIND_TICK_DONE, '0, '0, 1'b1);
         end
         OP_SCHEDULE: begin
            while (slot < SLOTS && armed[slot])
               slot++;
            if (slot == SLOTS) begin
               queue_result(KIND_FULL, '0, '0, 1'b1);
            end else begin
               sum = {1'b0, req_now_ms} + {{(TIME_BITS + 1 - DELAY_BITS){1'b0}}, req_delay_ms};
               // A carry out of the time width saturates the deadline.
               due_ms[slot]  = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
               tag_of[slot]  = req_event_tag;
               id_of[slot]   = id_counter;
               armed[slot]   = 1'b1;
               id_live[slot] = 1'b1;
               queue_result(KIND_SCHEDULED, id_counter, '0, 1'b1);
               id_counter    = id_counter + 1'b1;
            end
         end
         OP_CANCEL: begin
            while (slot < SLOTS && !(id_live[slot] && id_of[slot] == req_cancel_id))
               slot++;
            if (slot == SLOTS) begin
               queue_result(KIND_NOT_FOUND, '0, '0, 1'b1);
            end else begin
               armed[slot]   = 1'b0;
               id_live[slot] = 1'b0;
               queue_result(KIND_CANCELLED, '0, '0, 1'b1);
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_result();
      timer_result_type want;
      if (pending_results.size() == 0) begin
         report("unexpected result, kind", '0, 64'(rsp_kind));
      end else begin
         want = pending_results.pop_front();
         if (rsp_kind !== want.kind)
            report("kind", 64'(want.kind), 64'(rsp_kind));
         if (rsp_timer_id !== want.timer_id)
            report("timer_id", 64'(want.timer_id), 64'(rsp_timer_id));
         if (rsp_fired_tag !== want.fired_tag)
            report("fired_tag", 64'(want.fired_tag), 64'(rsp_fired_tag));
         if (rsp_last !== want.last)
            report("last", 64'(want.last), 64'(rsp_last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            armed[i]   = 1'b0;
            id_live[i] = 1'b0;
         end
         id_counter = '0;
         pending_results.delete();
      end else begin
         // Results of earlier items are checked before a new item is predicted.
         if (rsp_valid)
            check_result();
         if (start && !busy)
            apply_timer_op();
      end
      pending    <= pending_results.size();
      fail_count <= mismatches;
   end

endmodule

// ===== test/one_shot_timer_slot_scheduler_tb.sv =====
// Testbench top for the one-shot timer slot scheduler: stimulus, checker hookup and verdict.
`timescale 1ns / 1ps
module one_shot_timer_slot_scheduler_tb;
   import otss_pkg::*;

   localparam int SLOTS     = DEF_SLOTS;
   localparam int TIME_BITS = DEF_TIME_BITS;
   localparam int ID_BITS   = DEF_ID_BITS;
   localparam int TAG_BITS  = DEF_TAG_BITS;
   localparam int CYCLE_LIMIT = 50_000;
   localparam logic [OP_BITS-1:0]   OP_UNUSED = 2'd3;
   localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic [OP_BITS-1:0]    req_op = OP_TICK;
   logic [TIME_BITS-1:0]  req_now_ms = '0;
   logic [DELAY_BITS-1:0] req_delay_ms = '0;
   logic [TAG_BITS-1:0]   req_event_tag = '0;
   logic [ID_BITS-1:0]    req_cancel_id = '0;
   wire logic             busy;
   wire logic             rsp_valid;
   wire logic [KIND_BITS-1:0] rsp_kind;
   wire logic [ID_BITS-1:0]   rsp_timer_id;
   wire logic [TAG_BITS-1:0]  rsp_fired_tag;
   wire logic                 rsp_last;
   int fail_count;
   int pending;

   int                   cycles = 0;
   int                   idle_pct = 0;
   logic [TIME_BITS-1:0] sim_now_ms = '0;
   logic [ID_BITS-1:0]   seen_ids[$];

   always #5 clock = ~clock;

   one_shot_timer_slot_scheduler i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_now_ms    (req_now_ms),
      .req_delay_ms  (req_delay_ms),
      .req_event_tag (req_event_tag),
      .req_cancel_id (req_cancel_id),
      .rsp_valid     (rsp_valid),
      .rsp_kind      (rsp_kind),
      .rsp_timer_id  (rsp_timer_id),
      .rsp_fired_tag (rsp_fired_tag),
      .rsp_last      (rsp_last)
   );

   otss_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_now_ms    (req_now_ms),
      .req_delay_ms  (req_delay_ms),
      .req_event_tag (req_event_tag),
      .req_cancel_id (req_cancel_id),
      .rsp_valid     (rsp_valid),
      .rsp_kind      (rsp_kind),
      .rsp_timer_id  (rsp_timer_id),
      .rsp_fired_tag (rsp_fired_tag),
      .rsp_last      (rsp_last),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("** one_shot_timer_slot_scheduler: FAILED **");
         $finish;
      end
   end

   // Ids handed out by the block, so that most cancels name a real timer.
   always @(posedge clock) begin
      if (rsp_valid && rsp_kind == KIND_SCHEDULED) begin
         seen_ids.push_back(rsp_timer_id);
         if (seen_ids.size() > 48)
            void'(seen_ids.pop_front());
      end
   end

   task automatic send(input logic [OP_BITS-1:0] op, input logic [TIME_BITS-1:0] now,
                       input logic [DELAY_BITS-1:0] delay, input logic [TAG_BITS-1:0] tag,
                       input logic [ID_BITS-1:0] cid);
      while ($urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_op        <= op;
      req_now_ms    <= now;
      req_delay_ms  <= delay;
      req_event_tag <= tag;
      req_cancel_id <= cid;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
   endtask

   task automatic advance_time();
      int r;
      logic [63:0] wide;
      r    = $urandom_range(99, 0);
      wide = {$urandom, $urandom};
      if (r < 5)
         sim_now_ms = wide[TIME_BITS-1:0];
      else if (r < 7)
         sim_now_ms = TIME_MAX;
      else if (r < 9)
         sim_now_ms = '0;
      else
         sim_now_ms = sim_now_ms + TIME_BITS'($urandom_range(40, 0));
   endtask

   function automatic logic [DELAY_BITS-1:0] rand_delay();
      int          r;
      logic [31:0] wide;
      r    = $urandom_range(99, 0);
      wide = $urandom;
      if (r < 10)
         return '0;
      if (r < 20)
         return '1;
      if (r < 35)
         return wide[DELAY_BITS-1:0];
      return DELAY_BITS'($urandom_range(120, 1));
   endfunction

   function automatic logic [TAG_BITS-1:0] rand_tag();
      int          r;
      logic [31:0] wide;
      r    = $urandom_range(99, 0);
      wide = $urandom;
      if (r < 20)
         return '0;
      if (r < 30)
         return '1;
      return wide[TAG_BITS-1:0];
   endfunction

   function automatic logic [ID_BITS-1:0] pick_cancel_id();
      logic [31:0] wide;
      wide = $urandom;
      if (seen_ids.size() > 0 && $urandom_range(99, 0) < 80)
         return seen_ids[$urandom_range(seen_ids.size() - 1, 0)];
      return wide[ID_BITS-1:0];
   endfunction

   // Fills the table past full with due timers that all carry a tag, then one tick
   // fires them all.
   task automatic fill_and_flush();
      repeat (SLOTS + 1)
         send(OP_SCHEDULE, sim_now_ms, DELAY_BITS'($urandom_range(20, 0)),
              TAG_BITS'($urandom_range(16'hFFFF, 1)), ID_BITS'($urandom));
      sim_now_ms = sim_now_ms + 1000;
      send(OP_TICK, sim_now_ms, rand_delay(), rand_tag(), ID_BITS'($urandom));
   endtask

   task automatic run_random(input int n_items);
      int done_items;
      int r;
      int len;
      done_items = 0;
      while (done_items < n_items) begin
         r = $urandom_range(99, 0);
         if (r < 34) begin
            len = $urandom_range(6, 1);
            repeat (len) begin
               advance_time();
               send(OP_SCHEDULE, sim_now_ms, rand_delay(), rand_tag(), ID_BITS'($urandom));
            end
            done_items += len;
         end else if (r < 60) begin
            advance_time();
            send(OP_TICK, sim_now_ms, rand_delay(), rand_tag(), ID_BITS'($urandom));
            done_items++;
         end else if (r < 85) begin
            send(OP_CANCEL, sim_now_ms, rand_delay(), rand_tag(), pick_cancel_id());
            done_items++;
         end else begin
            send(OP_UNUSED, TIME_BITS'({$urandom, $urandom}), rand_delay(), rand_tag(),
                 ID_BITS'($urandom));
            done_items++;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 9;
      send(OP_TICK, 0, '0, '0, '0);
      send(OP_CANCEL, 0, '1, '1, '0);
      send(OP_UNUSED, TIME_MAX, '1, '1, '1);
      send(OP_SCHEDULE, 0, 0, 16'hFFFF, 0);
      send(OP_SCHEDULE, TIME_MAX, '1, 16'h0001, 0);
      send(OP_SCHEDULE, 1000, 0, 16'h0000, 0);
      send(OP_SCHEDULE, 5, 10, 16'hA5A5, 0);
      send(OP_SCHEDULE, TIME_MAX - 100, 50, 16'h5A5A, 0);
      // A deadline of zero is still pending and goes on the first tick.
      send(OP_TICK, 0, 0, 0, 0);
      send(OP_TICK, 15, 0, 0, 0);
      send(OP_TICK, 999, 0, 0, 0);
      send(OP_TICK, 1000, 0, 0, 0);
      // The fired timer keeps its id, so the first cancel finds it and the second not.
      send(OP_CANCEL, 1000, 0, 0, 3);
      send(OP_CANCEL, 1000, 0, 0, 3);
      send(OP_CANCEL, 1000, 0, 0, 16'hFFFF);
      send(OP_CANCEL, 1000, 0, 0, 1);
      send(OP_TICK, TIME_MAX, 0, 0, 0);
      send(OP_SCHEDULE, TIME_MAX, 0, 16'h1234, '1);
      send(OP_TICK, TIME_MAX - 1, 0, 0, 0);
      send(OP_TICK, TIME_MAX, 0, 0, 0);

      sim_now_ms = TIME_BITS'($urandom_range(5000, 0));
      fill_and_flush();
      run_random(20);
      drain();

      idle_pct = 61;
      run_random(20);
      drain();

      idle_pct = 0;
      run_random(16);
      drain();

      repeat (2 * SLOTS + 8) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("** one_shot_timer_slot_scheduler: PASSED **");
      else
         $display("** one_shot_timer_slot_scheduler: FAILED **");
      $finish;
   end

endmodule

// ===== one_shot_timer_slot_scheduler.f =====
rtl/otss_pkg.sv
rtl/otss_alu.sv
rtl/otss_slot_mem.sv
rtl/otss_ctrl.sv
rtl/one_shot_timer_slot_scheduler.sv
test/otss_checker.sv
test/one_shot_timer_slot_scheduler_tb.sv
